FILE: sv/fbfl_pkg.sv
// Package for the fixed-block free-list allocator: sizes, codes and shared types.
package fbfl_pkg;

	// Number of blocks the link memory can hold.
	localparam int DEPTH     = 64;
	// Pointer size in bytes. It must be a power of two, so that rounding up is a mask.
	localparam int PTR_BYTES = 4;

	localparam int IDX_W    = 6;
	localparam int CNT_W    = 7;
	localparam int LINK_W   = IDX_W + 1;
	localparam int SIZE_W   = 13;
	localparam int STRIDE_W = SIZE_W + 1;
	localparam int OFF_W    = 18;
	localparam int KIND_W   = 2;
	localparam int CFG_W    = 13;
	localparam int CFG_IDX_W = 1;

	localparam logic [STRIDE_W-1:0] ALIGN_MASK = STRIDE_W'(PTR_BYTES - 1);

	typedef enum logic [KIND_W-1:0] {
		KIND_INIT  = 2'd0,
		KIND_ALLOC = 2'd1,
		KIND_FREE  = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BLOCK_SIZE  = 1'b0,
		REG_BLOCK_COUNT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [SIZE_W-1:0] blk_bytes;
		logic [CNT_W-1:0]  blk_total;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [LINK_W-1:0] wdata;
		logic              re;
		logic [IDX_W-1:0]  raddr;
	} ram_req_t;

	typedef struct packed {
		logic              granted;
		logic [IDX_W-1:0]  out_index;
		logic [OFF_W-1:0]  byte_offset;
		logic [CNT_W-1:0]  free_blocks;
	} res_t;

endpackage

FILE: sv/fbfl_if.sv
// Valid/ready channel interfaces for operation and result beats.
interface fbfl_in_if import fbfl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [IDX_W-1:0]  block_index;
	logic              has_block;

	modport source (output valid, kind, block_index, has_block, input ready);
	modport sink (input valid, kind, block_index, has_block, output ready);
endinterface

interface fbfl_out_if import fbfl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              granted;
	logic [IDX_W-1:0]  out_index;
	logic [OFF_W-1:0]  byte_offset;
	logic [CNT_W-1:0]  free_blocks;

	modport source (output valid, granted, out_index, byte_offset, free_blocks, input ready);
	modport sink (input valid, granted, out_index, byte_offset, free_blocks, output ready);
endinterface

FILE: sv/fbfl_link_ram.sv
// Link memory: one next-block entry per block, one write and one registered read port.
module fbfl_link_ram import fbfl_pkg::*; (
	input  logic              clk,
	input  ram_req_t          req,
	output logic [LINK_W-1:0] rdata
);

	logic [LINK_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

FILE: sv/fbfl_ctrl.sv
// Sequencer for init, alloc and free: head, free count, init sweep and result formation.
module fbfl_ctrl import fbfl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              start,
	input  logic [KIND_W-1:0] kind,
	input  logic [IDX_W-1:0]  block_index,
	input  logic              has_block,
	output logic              idle,
	output ram_req_t          ram_req,
	input  logic [LINK_W-1:0] ram_rdata,
	output logic              res_vld,
	output res_t              res
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_INIT = 3'b100
	} state_t;

	state_t                state_q;
	logic [KIND_W-1:0]     op_kind_q;
	logic [IDX_W-1:0]      op_idx_q;
	logic                  op_has_q;
	logic [IDX_W-1:0]      head_q;
	logic                  head_ok_q;
	logic [CNT_W-1:0]      free_q;
	logic [CNT_W-1:0]      pool_count_q;
	logic [STRIDE_W-1:0]   stride_q;
	logic [IDX_W-1:0]      init_idx_q;

	logic                  cfg_ok;
	logic [CNT_W-1:0]      init_n;
	logic [STRIDE_W-1:0]   stride_new;
	logic                  sweep_last;
	logic                  free_ok;
	logic                  alloc_ok;
	logic [CNT_W-1:0]      free_next;
	logic [IDX_W+STRIDE_W-1:0] prod;

	assign idle       = (state_q == S_IDLE);
	assign cfg_ok     = (cfg.blk_bytes != '0) && (cfg.blk_total != '0);
	assign init_n     = (cfg.blk_total > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cfg.blk_total;
	assign stride_new = (STRIDE_W'(cfg.blk_bytes) + ALIGN_MASK) & ~ALIGN_MASK;
	assign sweep_last = ({1'b0, init_idx_q} == (pool_count_q - CNT_W'(1)));
	assign free_ok    = op_has_q && ({1'b0, op_idx_q} < pool_count_q);
	assign alloc_ok   = head_ok_q;
	assign prod       = (IDX_W+STRIDE_W)'(head_q) * (IDX_W+STRIDE_W)'(stride_q);

	always_comb begin
		free_next = free_q;
		if (state_q == S_EXEC) begin
			if (op_kind_q == KIND_ALLOC && alloc_ok && free_q != '0) begin
				free_next = free_q - CNT_W'(1);
			end else if (op_kind_q == KIND_FREE && free_ok && free_q < pool_count_q) begin
				free_next = free_q + CNT_W'(1);
			end
		end
	end

	always_comb begin
		ram_req = '0;
		case (state_q)
			S_IDLE: begin
				if (start && kind == KIND_ALLOC) begin
					ram_req.re    = 1'b1;
					ram_req.raddr = head_q;
				end
			end
			S_EXEC: begin
				if (op_kind_q == KIND_FREE && free_ok) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = op_idx_q;
					ram_req.wdata = {head_ok_q, head_q};
				end
			end
			S_INIT: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = init_idx_q;
				ram_req.wdata = {init_idx_q != '0, init_idx_q - IDX_W'(1)};
			end
			default: ram_req = '0;
		endcase
	end

	always_comb begin
		res_vld         = 1'b0;
		res.granted     = 1'b0;
		res.out_index   = '0;
		res.byte_offset = '0;
		res.free_blocks = free_next;
		case (state_q)
			S_EXEC: begin
				res_vld = 1'b1;
				if (op_kind_q == KIND_ALLOC && alloc_ok) begin
					res.granted     = 1'b1;
					res.out_index   = head_q;
					res.byte_offset = prod[OFF_W-1:0];
				end
			end
			S_INIT: begin
				if (sweep_last) begin
					res_vld         = 1'b1;
					res.granted     = 1'b1;
					res.free_blocks = pool_count_q;
				end
			end
			default: res_vld = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			head_ok_q    <= 1'b0;
			free_q       <= '0;
			pool_count_q <= '0;
			stride_q     <= '0;
			init_idx_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						if (kind == KIND_INIT && cfg_ok) begin
							state_q      <= S_INIT;
							pool_count_q <= init_n;
							stride_q     <= stride_new;
							init_idx_q   <= '0;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					free_q  <= free_next;
					if (op_kind_q == KIND_ALLOC && alloc_ok) begin
						head_q    <= ram_rdata[IDX_W-1:0];
						head_ok_q <= ram_rdata[LINK_W-1];
					end else if (op_kind_q == KIND_FREE && free_ok) begin
						head_q    <= op_idx_q;
						head_ok_q <= 1'b1;
					end
				end
				S_INIT: begin
					if (sweep_last) begin
						state_q   <= S_IDLE;
						head_q    <= init_idx_q;
						head_ok_q <= 1'b1;
						free_q    <= pool_count_q;
					end else begin
						init_idx_q <= init_idx_q + IDX_W'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && state_q == S_IDLE) begin
			op_kind_q <= kind;
			op_idx_q  <= block_index;
			op_has_q  <= has_block;
		end
	end

`ifndef SYNTHESIS
	// Outside an init sweep, which already holds the new pool size, the free count never
	// runs past the size of the pool.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_INIT) |-> (free_q <= pool_count_q))
		else $error("free count exceeds pool size");

	// An alloc in execution always follows a link read issued at acceptance.
	a_alloc_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && op_kind_q == KIND_ALLOC) |-> $past(ram_req.re))
		else $error("alloc executed without a link read");

	// The init sweep stays inside the pool it is building.
	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INIT) |-> ({1'b0, init_idx_q} < pool_count_q))
		else $error("init sweep beyond pool size");
`endif

endmodule

FILE: sv/fixed_block_free_list_allocator.sv
// Top level of the fixed-block free-list allocator: config registers, link memory and result stage.
//
// Operation beats arrive on req (kind, block_index, has_block) and each one gives exactly one
// result beat on rsp (granted, out_index, byte_offset, free_blocks). Kind init links blocks
// count-1 down to 0 so that the highest index is handed out first; alloc pops the list head;
// free pushes a block back, and a free without a block or outside the pool is ignored.
// Alloc and free each pass through the accept cycle, which for alloc issues the link memory
// read, and an execute state that updates the head and count; the sequencer takes no new
// operation until it is back in idle, so it is through with one before it takes the next.
// The link memory read is registered, which is why alloc needs the execute state. Init is
// accepted and then writes one link entry a cycle until every block of the pool, 1 to 64 of
// them, is linked. A result is formed in the last working cycle of its operation and passes
// a pending register and then the output register on its way to rsp.
// The two registers together let the block finish one operation while an earlier result is
// still waiting; once both are full, req.ready stays low until the receiver takes a beat.
// After reset the pool is empty: alloc fails, free is ignored, until a successful init.
// The block size and block count registers are written through cfg_we, cfg_index and
// cfg_data; the user must write them only while the block is idle, which the block itself
// does not enforce. Init alone samples them, so a live pool is not disturbed.
module fixed_block_free_list_allocator import fbfl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	fbfl_in_if.sink              req,
	fbfl_out_if.source           rsp
);

	cfg_t              cfg_q;
	ram_req_t          ram_req;
	logic [LINK_W-1:0] ram_rdata;
	logic              ctrl_idle;
	logic              res_vld;
	res_t              res;
	logic              start;

	// Result waiting for the output register, and the output register itself.
	logic              pend_q;
	res_t              pend_res_q;
	logic              out_valid_q;
	res_t              out_res_q;
	logic              out_free;

	// Configuration registers, to be written only while no operation is in flight; the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blk_bytes <= SIZE_W'(4);
			cfg_q.blk_total <= CNT_W'(DEPTH);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_BLOCK_SIZE:  cfg_q.blk_bytes <= cfg_data[SIZE_W-1:0];
				REG_BLOCK_COUNT: cfg_q.blk_total <= cfg_data[CNT_W-1:0];
				default:         cfg_q <= cfg_q;
			endcase
		end
	end

	// The output register frees up this cycle if it is empty or its beat is being taken.
	assign out_free  = !out_valid_q || rsp.ready;
	// A new operation is only taken when the pending slot will be empty after this edge,
	// so the sequencer always has somewhere to put its result.
	assign req.ready = ctrl_idle && (!pend_q || out_free);
	assign start     = req.valid && req.ready;

	fbfl_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.start       (start),
		.kind        (req.kind),
		.block_index (req.block_index),
		.has_block   (req.has_block),
		.idle        (ctrl_idle),
		.ram_req     (ram_req),
		.ram_rdata   (ram_rdata),
		.res_vld     (res_vld),
		.res         (res)
	);

	fbfl_link_ram u_link_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	// Pending slot: loaded by the sequencer, drained into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_vld) begin
				pend_q <= 1'b1;
			end else if (pend_q && out_free) begin
				pend_q <= 1'b0;
			end
			if (pend_q && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld) begin
			pend_res_q <= res;
		end
		if (pend_q && out_free) begin
			out_res_q <= pend_res_q;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.granted     = out_res_q.granted;
	assign rsp.out_index   = out_res_q.out_index;
	assign rsp.byte_offset = out_res_q.byte_offset;
	assign rsp.free_blocks = out_res_q.free_blocks;

endmodule
